>>> rtl/nfas_pkg.sv
// Package: constants and payload types for the non-IEEE float adder.
`default_nettype none
package nfas_pkg;
    localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
    localparam logic [31:0] MAG_MASK   = 32'h7fff_ffff;
    localparam logic [0:0]  OP_ADD     = 1'b0;
    localparam logic [0:0]  OP_SUB     = 1'b1;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [31:0] sum_word;
    } t_out_item;
endpackage
`default_nettype wire

>>> rtl/nfas_if.sv
// Interfaces: valid/ready channels for operands and results.
`default_nettype none
interface nfas_in_if;
    logic              valid;
    logic              ready;
    nfas_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nfas_out_if;
    logic               valid;
    logic               ready;
    nfas_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/nfas_core.sv
// Core: combinational add/subtract datapath for one operand pair.
`default_nettype none
module nfas_core (
    input  wire logic [0:0]  i_opcode,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_sum
);
    logic [31:0] bs, a, b, am, bm, sm, nm;
    logic [7:0]  ae, be, gap;
    logic [5:0]  lz;
    logic [9:0]  ce;

    always_comb begin
        bs = (i_opcode == nfas_pkg::OP_SUB) ? (i_b ^ nfas_pkg::SIGN_BIT) : i_b;
        if ((i_a & nfas_pkg::MAG_MASK) < (bs & nfas_pkg::MAG_MASK)) begin
            a = bs;
            b = i_a;
        end else begin
            a = i_a;
            b = bs;
        end
        ae  = a[30:23];
        be  = b[30:23];
        gap = ae - be;
        am  = {7'd0, 1'b1, a[22:0], 1'b0};
        bm  = {7'd0, 1'b1, b[22:0], 1'b0};
        if (gap > 8'd24) begin
            bm = '0;
        end else begin
            bm = bm >> gap[4:0];
        end
        sm = (a[31] ^ b[31]) ? (am - bm) : (am + bm);
        lz = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (sm[i]) begin
                lz = 6'(31 - i);
            end
        end
        nm = (sm << lz[4:0]) >> 8;
        ce = {2'b00, ae} + 10'd7 - {4'd0, lz};
        if (be == 8'd0) begin
            o_sum = (ae != 8'd0) ? a : (a & b & nfas_pkg::SIGN_BIT);
        end else if (a == (b ^ nfas_pkg::SIGN_BIT)) begin
            o_sum = '0;
        end else if (lz[5]) begin
            o_sum = '0;
        end else if (ce[9] || ce == 10'd0) begin
            o_sum = a & nfas_pkg::SIGN_BIT;
        end else if (ce[8]) begin
            o_sum = a | nfas_pkg::MAG_MASK;
        end else begin
            o_sum = {a[31], ce[7:0], nm[22:0]};
        end
    end
endmodule
`default_nettype wire

>>> rtl/nonieee_float32_add_sub.sv
// Top level: registered single-pass non-IEEE float32 adder/subtractor.
// One operation per cycle while the output is not stalled: an operand transfer
// is registered in the input register, passes the combinational add/normalize
// path and lands in the output register. The input is taken whenever the
// input register is empty or its contents move on, which is when the output
// register is empty or its result is transferred.
`default_nettype none
module nonieee_float32_add_sub (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nfas_in_if.sink    i_in,
    nfas_out_if.source o_out
);
    logic               r_sv, r_ov, adv_s, adv_o;
    nfas_pkg::t_in_item r_s;
    logic [31:0]        r_sum, sum;

    assign adv_o      = !r_ov || o_out.ready;
    assign adv_s      = !r_sv || adv_o;
    assign i_in.ready = adv_s;

    nfas_core u_core (
        .i_opcode (r_s.opcode),
        .i_a      (r_s.operand_a),
        .i_b      (r_s.operand_b),
        .o_sum    (sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv_s) r_sv <= i_in.valid;
            if (adv_o) r_ov <= r_sv;
        end
        if (adv_s) r_s <= i_in.payload;
        if (adv_o && r_sv) r_sum <= sum;
    end

    assign o_out.valid            = r_ov;
    assign o_out.payload.sum_word = r_sum;
endmodule
`default_nettype wire
